@@ hdl/tinted_alpha_over_blend_macros.svh @@
// Assertion helpers, clocked on clk and held off during rst.
`ifndef TINTED_ALPHA_OVER_BLEND_MACROS_SVH
`define TINTED_ALPHA_OVER_BLEND_MACROS_SVH

// cond implies expr at the same edge
`define ASSERT_IMPL(name, cond, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// expr must never hold
`define ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

@@ hdl/tab_pkg.sv @@
`timescale 1ns / 1ps

package tab_pkg;

  localparam int unsigned CH_W               = 8;
  localparam int unsigned NUM_CH             = 3;
  localparam int unsigned PROD_W             = 2 * CH_W;
  localparam int unsigned NUM_W              = 3 * CH_W;
  localparam int unsigned DIV_BITS_PER_STAGE = 4;
  localparam int unsigned DIV_STAGES         = NUM_W / DIV_BITS_PER_STAGE;
  localparam int unsigned FRONT_STAGES       = 3;
  localparam int unsigned BACK_STAGES        = 2;
  localparam int unsigned PIPE_LATENCY       = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  localparam logic [CH_W-1:0] FULL_CH     = 8'd255;
  localparam logic [15:0]     RECIP_255   = 16'd32897;
  localparam int unsigned     RECIP_SHIFT = 23;
  localparam int unsigned     QEST_W      = 17;

  typedef enum logic [1:0] {
    DEPTH_8    = 2'd0,
    DEPTH_16   = 2'd1,
    DEPTH_32   = 2'd2,
    DEPTH_NONE = 2'd3
  } depth_t;

  typedef enum logic [1:0] {
    REG_DEPTH = 2'd0,
    REG_KEY   = 2'd1,
    REG_TINT  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;
  } pix_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] out_pixel;
  } pix_out_t;

  typedef struct packed {
    depth_t      depth_mode;
    logic [15:0] key_colour;
    logic [23:0] tint_rgb;
  } cfg_t;

  typedef struct packed {
    logic            we;
    logic            blend;
    logic [31:0]     pix;
    logic [CH_W-1:0] fa;
  } side_t;

  typedef struct packed {
    side_t                        side;
    logic [NUM_CH-1:0][NUM_W-1:0] n1;
    logic [NUM_CH-1:0][NUM_W-1:0] n2;
  } front_out_t;

  typedef struct packed {
    logic [CH_W-1:0]  rem;
    logic [NUM_W-1:0] nq;
  } div_state_t;

  // first guess of x / 255, may be one high
  function automatic logic [QEST_W-1:0] div255_est(input logic [NUM_W-1:0] x);
    logic [NUM_W+15:0] prod;
    prod = {16'b0, x} * {{NUM_W{1'b0}}, RECIP_255};
    return prod[RECIP_SHIFT +: QEST_W];
  endfunction

  function automatic logic [QEST_W-1:0] div255_fix(input logic [QEST_W-1:0] est,
                                                    input logic [NUM_W-1:0]  x);
    logic [NUM_W:0] back;
    back = {{(NUM_W+1-QEST_W){1'b0}}, est} * {{(NUM_W+1-CH_W){1'b0}}, FULL_CH};
    if (back > {1'b0, x}) begin
      return QEST_W'(est - 1'b1);
    end
    return est;
  endfunction

endpackage

@@ hdl/tab_front.sv @@
`timescale 1ns / 1ps

module tab_front import tab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  pix_in_t    pixels,
  input  cfg_t       cfg,
  output logic       out_valid,
  output front_out_t out
);

  logic [CH_W-1:0]   sa, da, sa_inv;
  logic [PROD_W-1:0] pa;
  logic [NUM_CH-1:0][PROD_W-1:0] n1, m;
  side_t side;

  logic                          v1;
  side_t                         side1;
  logic [CH_W-1:0]               sa_inv1;
  logic [PROD_W-1:0]             pa1;
  logic [NUM_CH-1:0][PROD_W-1:0] n1_1, m1;

  logic                          v2;
  side_t                         side2;
  logic [QEST_W-1:0]             pa_est2;
  logic [PROD_W-1:0]             pa2;
  logic [NUM_CH-1:0][PROD_W-1:0] n1_2;
  logic [NUM_CH-1:0][NUM_W-1:0]  n2_2;

  logic [QEST_W-1:0] q_a;
  logic [CH_W-1:0]   fa_raw;

  always_comb begin
    sa     = pixels.src_pixel[31:24];
    da     = pixels.dst_pixel[31:24];
    sa_inv = FULL_CH - sa;
    pa     = {8'b0, sa_inv} * {8'b0, FULL_CH - da};
    for (int c = 0; c < NUM_CH; c++) begin
      n1[c] = {8'b0, sa} * {8'b0, cfg.tint_rgb[c*CH_W +: CH_W]};
      m[c]  = {8'b0, da} * {8'b0, pixels.dst_pixel[c*CH_W +: CH_W]};
    end
    side.we    = 1'b0;
    side.blend = 1'b0;
    side.pix   = pixels.dst_pixel;
    side.fa    = '0;
    case (cfg.depth_mode)
      DEPTH_8: begin
        if ({8'b0, pixels.src_pixel[7:0]} != cfg.key_colour) begin
          side.we  = 1'b1;
          side.pix = {24'b0, pixels.src_pixel[7:0]};
        end
      end
      DEPTH_16: begin
        if (pixels.src_pixel[15:0] != cfg.key_colour) begin
          side.we  = 1'b1;
          side.pix = {16'b0, pixels.src_pixel[15:0]};
        end
      end
      DEPTH_32: begin
        if (sa != '0) begin
          side.we    = 1'b1;
          side.blend = 1'b1;
        end
      end
      default: begin
        side.we = 1'b0;
      end
    endcase
  end

  always_comb begin
    q_a    = div255_fix(pa_est2, {8'b0, pa2});
    fa_raw = FULL_CH - q_a[CH_W-1:0];
    if (fa_raw == '0) begin
      fa_raw = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    side1   <= side;
    sa_inv1 <= sa_inv;
    pa1     <= pa;
    n1_1    <= n1;
    m1      <= m;

    side2   <= side1;
    pa_est2 <= div255_est({8'b0, pa1});
    pa2     <= pa1;
    n1_2    <= n1_1;
    for (int c = 0; c < NUM_CH; c++) begin
      n2_2[c] <= {8'b0, m1[c]} * {16'b0, sa_inv1};
    end

    out.side.we    <= side2.we;
    out.side.blend <= side2.blend;
    out.side.pix   <= side2.pix;
    out.side.fa    <= fa_raw;
    for (int c = 0; c < NUM_CH; c++) begin
      out.n1[c] <= {8'b0, n1_2[c]};
    end
    out.n2 <= n2_2;
  end

endmodule

@@ hdl/tab_div.sv @@
`timescale 1ns / 1ps

module tab_div import tab_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [CH_W-1:0]  den,
  output logic [NUM_W-1:0] quo
);

  div_state_t      st [DIV_STAGES];
  logic [CH_W-1:0] dd [DIV_STAGES];

  function automatic div_state_t div_steps(input div_state_t s_in, input logic [CH_W-1:0] d);
    div_state_t  s;
    logic [CH_W:0] t;
    s = s_in;
    for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
      t    = {s.rem, s.nq[NUM_W-1]};
      s.nq = {s.nq[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        s.rem   = CH_W'(t - {1'b0, d});
        s.nq[0] = 1'b1;
      end else begin
        s.rem = t[CH_W-1:0];
      end
    end
    return s;
  endfunction

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        st[s] <= div_steps(div_state_t'({{CH_W{1'b0}}, num}), den);
        dd[s] <= den;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        st[s] <= div_steps(st[s-1], dd[s-1]);
        dd[s] <= dd[s-1];
      end
    end
  end

  assign quo = st[DIV_STAGES-1].nq;

endmodule

@@ hdl/tab_back.sv @@
`timescale 1ns / 1ps

module tab_back import tab_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  side_t                        side,
  input  logic [NUM_CH-1:0][NUM_W-1:0] q1,
  input  logic [NUM_CH-1:0][NUM_W-1:0] q2,
  output logic                         done,
  output pix_out_t                     result
);

  logic                          va;
  side_t                         side_a;
  logic [NUM_CH-1:0][PROD_W-1:0] q1_a;
  logic [NUM_CH-1:0][NUM_W-1:0]  q2_a;
  logic [NUM_CH-1:0][QEST_W-1:0] est_a;

  logic [NUM_CH-1:0][CH_W-1:0]   fc;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      logic [QEST_W-1:0] qd;
      logic [QEST_W:0]   sum;
      qd  = div255_fix(est_a[c], q2_a[c]);
      sum = {2'b0, q1_a[c]} + {1'b0, qd};
      fc[c] = (sum > {{(QEST_W+1-CH_W){1'b0}}, FULL_CH}) ? FULL_CH : sum[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va   <= 1'b0;
      done <= 1'b0;
    end else begin
      va   <= in_valid;
      done <= va;
    end
  end

  always_ff @(posedge clk) begin
    side_a <= side;
    for (int c = 0; c < NUM_CH; c++) begin
      q1_a[c]  <= q1[c][PROD_W-1:0];
      q2_a[c]  <= q2[c];
      est_a[c] <= div255_est(q2[c]);
    end
    result.write_enable <= side_a.we;
    result.out_pixel    <= side_a.blend ? {side_a.fa, fc[2], fc[1], fc[0]} : side_a.pix;
  end

endmodule

@@ hdl/tinted_alpha_over_blend.sv @@
// Tinted alpha-over glyph compositor, one pixel per clock. A pixel is taken whenever start is
// high; busy is always low, and cfg_ready is always high. Each pixel's result appears on result
// for one cycle with done high, after it has passed 3 front stages of multiplies and the alpha
// divide by 255, 6 stages of the divide by final alpha at 4 quotient bits per stage, and 2 back
// stages for the divide by 255 and saturation. Results leave in input order and cannot be held
// off; a full pipeline of pixels may be in flight at once. Write the configuration only while
// no pixel is in flight.
`timescale 1ns / 1ps
`include "tinted_alpha_over_blend_macros.svh"

module tinted_alpha_over_blend import tab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pix_in_t     pixels,
  output logic        done,
  output pix_out_t    result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cfg_t       cfg;
  logic       f_valid;
  front_out_t f_out;

  logic  sv [DIV_STAGES];
  side_t sd [DIV_STAGES];

  logic [NUM_CH-1:0][NUM_W-1:0] q1, q2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_mode <= DEPTH_32;
      cfg.key_colour <= 16'h0000;
      cfg.tint_rgb   <= 24'hFFFFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEPTH: cfg.depth_mode <= depth_t'(cfg_data[1:0]);
        REG_KEY:   cfg.key_colour <= cfg_data[15:0];
        REG_TINT:  cfg.tint_rgb   <= cfg_data;
        default:   cfg.depth_mode <= cfg.depth_mode;
      endcase
    end
  end

  tab_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .pixels    (pixels),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out       (f_out)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    tab_div u_div_src (
      .clk (clk),
      .num (f_out.n1[c]),
      .den (f_out.side.fa),
      .quo (q1[c])
    );
    tab_div u_div_dst (
      .clk (clk),
      .num (f_out.n2[c]),
      .den (f_out.side.fa),
      .quo (q2[c])
    );
  end

  // sideband rides alongside the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        sv[s] <= 1'b0;
      end
    end else begin
      sv[0] <= f_valid;
      for (int s = 1; s < DIV_STAGES; s++) begin
        sv[s] <= sv[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    sd[0] <= f_out.side;
    for (int s = 1; s < DIV_STAGES; s++) begin
      sd[s] <= sd[s-1];
    end
  end

  tab_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sv[DIV_STAGES-1]),
    .side     (sd[DIV_STAGES-1]),
    .q1       (q1),
    .q2       (q2),
    .done     (done),
    .result   (result)
  );

  `ASSERT_NEVER(done_without_beat, done && !$past(start, PIPE_LATENCY), "result with no input beat")
  `ASSERT_IMPL(skip_keeps_dst, done && !result.write_enable, result.out_pixel == $past(pixels.dst_pixel, PIPE_LATENCY), "skipped pixel lost dst value")

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import tab_pkg::*;

  localparam int unsigned CH_MAX        = 255;
  localparam logic [1:0]  REG_SPARE     = 2'd3;
  localparam int          STALL_LIMIT   = 1000;
  localparam int          RANDOM_PHASES = 20;
  localparam int          PHASE_PIXELS  = 100;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  pix_in_t     pixels;
  logic        done;
  pix_out_t    result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  depth_t      m_depth;
  logic [15:0] m_key;
  logic [23:0] m_tint;
  pix_out_t    pending_px[$];
  int          err_cnt = 0;
  int          stall_cnt = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;

  tinted_alpha_over_blend u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixels    (pixels),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] over_channel(int unsigned sa, int unsigned tc,
                                              int unsigned da, int unsigned dc,
                                              int unsigned fa);
    int unsigned v;
    v = (sa * tc) / fa + ((da * dc * (CH_MAX - sa)) / fa) / CH_MAX;
    return (v > CH_MAX) ? 8'hFF : v[7:0];
  endfunction

  function automatic pix_out_t blend_pixel(pix_in_t px);
    pix_out_t    r;
    int unsigned sa;
    int unsigned da;
    int unsigned fa;
    logic [31:0] d;
    d              = px.dst_pixel;
    r.write_enable = 1'b0;
    r.out_pixel    = d;
    case (m_depth)
      DEPTH_8: begin
        if ({8'h00, px.src_pixel[7:0]} != m_key) begin
          r.write_enable = 1'b1;
          r.out_pixel    = {24'h0, px.src_pixel[7:0]};
        end
      end
      DEPTH_16: begin
        if (px.src_pixel[15:0] != m_key) begin
          r.write_enable = 1'b1;
          r.out_pixel    = {16'h0, px.src_pixel[15:0]};
        end
      end
      DEPTH_32: begin
        sa = 32'(px.src_pixel[31:24]);
        if (sa != 0) begin
          da = 32'(d[31:24]);
          fa = CH_MAX - ((CH_MAX - sa) * (CH_MAX - da)) / CH_MAX;
          if (fa == 0) fa = 1;
          r.write_enable = 1'b1;
          r.out_pixel    = {fa[7:0],
                            over_channel(sa, 32'(m_tint[23:16]), da, 32'(d[23:16]), fa),
                            over_channel(sa, 32'(m_tint[15:8]),  da, 32'(d[15:8]),  fa),
                            over_channel(sa, 32'(m_tint[7:0]),   da, 32'(d[7:0]),   fa)};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // scoreboard: results first, then new pixels, then register writes
  always @(posedge clk) begin
    pix_out_t want;
    bit       moved;
    if (rst) begin
      m_depth   = DEPTH_32;
      m_key     = 16'h0000;
      m_tint    = 24'hFFFFFF;
      stall_cnt = 0;
    end else begin
      moved = 1'b0;
      if (done) begin
        moved = 1'b1;
        if (pending_px.size() == 0) begin
          $error("result with no pixel pending: write_enable=%0b out_pixel=%h",
                 result.write_enable, result.out_pixel);
          err_cnt++;
        end else begin
          want = pending_px.pop_front();
          if (result.write_enable !== want.write_enable) begin
            $error("write_enable: expected %0b, got %0b", want.write_enable,
                   result.write_enable);
            err_cnt++;
          end
          if (result.out_pixel !== want.out_pixel) begin
            $error("out_pixel: expected %h, got %h", want.out_pixel, result.out_pixel);
            err_cnt++;
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        pending_px.push_back(blend_pixel(pixels));
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_DEPTH: m_depth = depth_t'(cfg_data[1:0]);
          REG_KEY:   m_key   = cfg_data[15:0];
          REG_TINT:  m_tint  = cfg_data;
          default: ;
        endcase
      end
      stall_cnt = moved ? 0 : stall_cnt + 1;
    end
  end

  initial begin
    while (stall_cnt < STALL_LIMIT) @(posedge clk);
    $display("** tinted_alpha_over_blend: FAILED **");
    $finish;
  end

  task automatic send_pixel(pix_in_t px);
    @(negedge clk);
    start  <= 1'b1;
    pixels <= px;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      start  <= 1'b0;
      pixels <= {$urandom(), $urandom()};
    end
  endtask

  task automatic pace();
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: idle_for($urandom_range(0, 3));
        5, 6, 7:       idle_for($urandom_range(4, 12));
        8:             idle_for($urandom_range(20, 40));
        default: ;
      endcase
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 24'($urandom());
  endtask

  // unused data bits above each register's width carry junk
  task automatic set_config(depth_t d, logic [15:0] key, logic [23:0] tint);
    logic [21:0] junk;
    drain();
    junk = 22'($urandom());
    write_reg(REG_DEPTH, {junk, d});
    junk = 22'($urandom());
    write_reg(REG_KEY, {junk[7:0], key});
    write_reg(REG_TINT, tint);
  endtask

  function automatic pix_in_t rand_pixel(depth_t d, logic [15:0] key);
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  sa;
    logic [7:0]  da;
    src = $urandom();
    dst = $urandom();
    case (d)
      DEPTH_8:  if ($urandom_range(0, 1)) src[7:0] = key[7:0];
      DEPTH_16: if ($urandom_range(0, 1)) src[15:0] = key;
      DEPTH_32: begin
        case ($urandom_range(0, 7))
          0:       sa = 8'h00;
          1:       sa = 8'hFF;
          2:       sa = 8'h01;
          default: sa = 8'($urandom());
        endcase
        case ($urandom_range(0, 3))
          0:       da = 8'h00;
          1:       da = 8'hFF;
          default: da = 8'($urandom());
        endcase
        src[31:24] = sa;
        dst[31:24] = da;
      end
      default: ;
    endcase
    return {src, dst};
  endfunction

  task automatic test_reset_values();
    send_pixel({32'h00123456, 32'hA0B0C0D0});
    send_pixel({32'hFF000000, 32'h00000000});
    send_pixel({32'h80FFFFFF, 32'h80808080});
  endtask

  task automatic test_blend_extremes();
    set_config(DEPTH_32, 16'h0000, 24'h000000);
    send_pixel({32'h01FFFFFF, 32'h00FFFFFF});
    send_pixel({32'h01000000, 32'hFFFFFFFF});
    send_pixel({32'hFF000000, 32'hFFFFFFFF});
    set_config(DEPTH_32, 16'hFFFF, 24'hFFFFFF);
    send_pixel({32'hFFFFFFFF, 32'hFFFFFFFF});
    send_pixel({32'h01000000, 32'hFF000000});
    send_pixel({32'h00FFFFFF, 32'h12345678});
    set_config(DEPTH_32, 16'h0000, 24'($urandom()));
    send_pixel({32'h7F000000, 32'h80FFFFFF});
  endtask

  task automatic test_key_8bit();
    set_config(DEPTH_8, 16'h005A, 24'($urandom()));
    send_pixel({32'hFFFFFF5A, $urandom()});
    send_pixel({32'h0000005B, $urandom()});
    send_pixel({32'hFFFFFFFF, $urandom()});
    // key wider than a byte can never match
    set_config(DEPTH_8, 16'h015A, 24'($urandom()));
    send_pixel({32'h0000005A, $urandom()});
    set_config(DEPTH_8, 16'h0000, 24'($urandom()));
    send_pixel({32'hFFFFFF00, $urandom()});
  endtask

  task automatic test_key_16bit();
    set_config(DEPTH_16, 16'hFFFF, 24'($urandom()));
    send_pixel({32'h1234FFFF, $urandom()});
    send_pixel({32'hFFFF0000, $urandom()});
    set_config(DEPTH_16, 16'h0000, 24'($urandom()));
    send_pixel({32'hFFFF0000, $urandom()});
    send_pixel({32'h00000001, $urandom()});
  endtask

  task automatic test_unsupported_depth();
    set_config(DEPTH_NONE, 16'($urandom()), 24'($urandom()));
    send_pixel({32'hFFFFFFFF, $urandom()});
    send_pixel({$urandom(), $urandom()});
  endtask

  task automatic test_spare_index();
    set_config(DEPTH_32, 16'h0000, 24'h102030);
    write_reg(REG_SPARE, 24'($urandom()));
    send_pixel({32'hC0000000, 32'h40A0B0C0});
    send_pixel({32'hFF000000, 32'h00000000});
  endtask

  task automatic test_random_phases();
    depth_t      d;
    logic [15:0] key;
    logic [23:0] tint;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 4) begin
        d = depth_t'(ph);
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    d = DEPTH_8;
          2, 3:    d = DEPTH_16;
          9:       d = DEPTH_NONE;
          default: d = DEPTH_32;
        endcase
      end
      case (ph % 4)
        0:       key = 16'h0000;
        1:       key = 16'hFFFF;
        2:       key = 16'($urandom_range(0, 255));
        default: key = 16'($urandom());
      endcase
      case (ph % 3)
        0:       tint = 24'h000000;
        1:       tint = 24'hFFFFFF;
        default: tint = 24'($urandom());
      endcase
      set_config(d, key, tint);
      steady     = (ph % 5 == 3);
      burst_left = 0;
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (ph % 7 == 2 && i == PHASE_PIXELS / 2) drain();
        send_pixel(rand_pixel(d, key));
        pace();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    pixels    = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEPTH;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_blend_extremes();
    test_key_8bit();
    test_key_16bit();
    test_unsupported_depth();
    test_spare_index();
    test_random_phases();

    drain();
    repeat (PIPE_LATENCY + 8) @(negedge clk);
    if (err_cnt == 0) begin
      $display("** tinted_alpha_over_blend: PASSED **");
    end else begin
      $display("** tinted_alpha_over_blend: FAILED **");
    end
    $finish;
  end

endmodule
